// ===== hw/rtl/step_tracker_with_backlash_unit_macros.svh =====
// Assertion macros shared by the step tracker RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef STEP_TRACKER_WITH_BACKLASH_UNIT_MACROS_SVH
`define STEP_TRACKER_WITH_BACKLASH_UNIT_MACROS_SVH

// Same-cycle implication check.
`ifndef SYNTH
`define STBU_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("stbu: same-cycle check failed");
`else
`define STBU_ASSERT_IMP(lbl, clk, rst, ante, cons)
`endif

// Next-cycle implication check.
`ifndef SYNTH
`define STBU_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("stbu: next-cycle check failed");
`else
`define STBU_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ===== hw/rtl/stbu_pkg.sv =====
// Package for the step tracker: command codes, register indexes,
// fixed widths of the period arithmetic and controller/datapath structs.
package stbu_pkg;

   // Input command codes (req_tuser).
   localparam logic [1:0] CMD_TICK   = 2'd0;
   localparam logic [1:0] CMD_RATE   = 2'd1;
   localparam logic [1:0] CMD_LOAD   = 2'd2;
   localparam logic [1:0] CMD_TARGET = 2'd3;

   // Configuration register indexes.
   localparam logic [1:0] CSR_TRACK     = 2'd0;
   localparam logic [1:0] CSR_BL_AMOUNT = 2'd1;
   localparam logic [1:0] CSR_BL_RATE   = 2'd2;

   // Period division: quotient bits, numerator, divisor and remainder widths.
   localparam int DIV_STEPS = 31;
   localparam int CNT_W     = $clog2(DIV_STEPS);
   localparam int NUM_W     = 43;
   localparam int DEN_W     = 33;
   localparam int REM_W     = 34;
   localparam int F65_W     = 39;
   localparam int LHS_W     = 18;

   // Twice 65536e6: the period numerator for a slew size of one.
   localparam logic [63:0] TWO_N_BASE = 64'd131072000000;
   // Range limit: 2048 * slew_size must not exceed 65 * rate.
   localparam logic [31:0] RANGE_BASE = 32'd2048;

   typedef struct packed {
      logic tick_target;
      logic rate_abs;
      logic rate_scale;
      logic div_init;
      logic div_step;
      logic rate_done;
      logic tick_step;
      logic load_pos;
      logic set_target;
      logic emit;
   } stbu_cmd_type;

   typedef struct packed {
      logic out_hold;
   } stbu_stat_type;

endpackage

// ===== hw/rtl/stbu_ctrl.sv =====
// Controller of the step tracker: sequences ticks, rate updates and writes.
// Depends on stbu_pkg and the assertion macro header.
`include "step_tracker_with_backlash_unit_macros.svh"

module stbu_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [1:0]            req_tuser,
   input  stbu_pkg::stbu_stat_type dp_stat,
   output stbu_pkg::stbu_cmd_type  ctl_cmd
);
   import stbu_pkg::*;

   localparam logic [2:0] S_IDLE       = 3'd0;
   localparam logic [2:0] S_RATE_SCALE = 3'd1;
   localparam logic [2:0] S_DIV_INIT   = 3'd2;
   localparam logic [2:0] S_DIV        = 3'd3;
   localparam logic [2:0] S_RATE_DONE  = 3'd4;
   localparam logic [2:0] S_TICK_STEP  = 3'd5;
   localparam logic [2:0] S_EMIT       = 3'd6;

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] div_cnt_ff, div_cnt_in;

   always_comb begin
      state_in   = state_ff;
      div_cnt_in = div_cnt_ff;
      ctl_cmd    = '0;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               case (req_tuser)
                  CMD_TICK: begin
                     ctl_cmd.tick_target = 1'b1;
                     state_in = S_TICK_STEP;
                  end
                  CMD_RATE: begin
                     ctl_cmd.rate_abs = 1'b1;
                     state_in = S_RATE_SCALE;
                  end
                  CMD_LOAD: begin
                     ctl_cmd.load_pos = 1'b1;
                     state_in = S_EMIT;
                  end
                  CMD_TARGET: begin
                     ctl_cmd.set_target = 1'b1;
                     state_in = S_EMIT;
                  end
                  default: begin
                     state_in = S_EMIT;
                  end
               endcase
            end
         end
         S_RATE_SCALE: begin
            ctl_cmd.rate_scale = 1'b1;
            state_in = S_DIV_INIT;
         end
         S_DIV_INIT: begin
            ctl_cmd.div_init = 1'b1;
            div_cnt_in = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            ctl_cmd.div_step = 1'b1;
            div_cnt_in = div_cnt_ff + CNT_W'(1);
            if (div_cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               state_in = S_RATE_DONE;
            end
         end
         S_RATE_DONE: begin
            ctl_cmd.rate_done = 1'b1;
            state_in = S_EMIT;
         end
         S_TICK_STEP: begin
            ctl_cmd.tick_step = 1'b1;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (!dp_stat.out_hold) begin
               ctl_cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         div_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         div_cnt_ff <= div_cnt_in;
      end
   end

   `STBU_ASSERT_IMP(a_div_cnt_range, clock, reset, state_ff == S_DIV, div_cnt_ff < CNT_W'(DIV_STEPS))
   `STBU_ASSERT_IMP(a_emit_free, clock, reset, ctl_cmd.emit, !dp_stat.out_hold)
   `STBU_ASSERT_NXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready)
   `STBU_ASSERT_IMP(a_one_step_cmd, clock, reset, 1'b1, $onehot0({ctl_cmd.rate_scale, ctl_cmd.div_init, ctl_cmd.div_step, ctl_cmd.rate_done, ctl_cmd.tick_step, ctl_cmd.emit}))

endmodule

// ===== hw/rtl/stbu_dpath.sv =====
// Datapath of the step tracker: positions, backlash state, configuration,
// the iterative period divider and the result register. Depends on stbu_pkg.
module stbu_dpath #(
   parameter int POSITION_WIDTH = 32,
   parameter int SLEW_STEP      = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  stbu_pkg::stbu_cmd_type  ctl_cmd,
   output stbu_pkg::stbu_stat_type dp_stat,
   input  logic signed [31:0]    req_rate,
   input  logic signed [31:0]    req_position,
   input  logic                  csr_write,
   input  logic [1:0]            csr_index,
   input  logic [30:0]           csr_data,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [127:0]          rsp_tdata
);
   import stbu_pkg::*;

   localparam int PW = POSITION_WIDTH;
   localparam logic [NUM_W-1:0] TWO_N_ONE  = NUM_W'(TWO_N_BASE);
   localparam logic [NUM_W-1:0] TWO_N_SLEW = NUM_W'(TWO_N_BASE * 64'(SLEW_STEP));
   localparam logic [LHS_W-1:0] LHS_ONE    = LHS_W'(RANGE_BASE);
   localparam logic [LHS_W-1:0] LHS_SLEW   = LHS_W'(RANGE_BASE * 32'(SLEW_STEP));

   // Configuration.
   logic        track_ff, track_in;
   logic [15:0] bl_amount_ff, bl_amount_in;
   logic [30:0] bl_rate_ff, bl_rate_in;

   // Architectural state.
   logic [PW-1:0]      motor_ff, motor_in;
   logic [PW-1:0]      target_ff, target_in;
   logic signed [17:0] bl_taken_ff, bl_taken_in;
   logic               bl_flag_ff, bl_flag_in;
   logic signed [7:0]  step_inc_ff, step_inc_in;
   logic [6:0]         slew_ff, slew_in;
   logic [30:0]        period_ff, period_in;

   // Rate update scratch.
   logic [31:0]        f_ff, f_in;
   logic               dir_nz_ff, dir_nz_in;
   logic               dir_neg_ff, dir_neg_in;
   logic [F65_W-1:0]   f65_ff, f65_in;
   logic               slew_sel_ff, slew_sel_in;
   logic               in_range_ff, in_range_in;
   logic [DEN_W-1:0]   den_ff, den_in;
   logic [REM_W-1:0]   rem_ff, rem_in;
   logic [DIV_STEPS-1:0] numlo_ff, numlo_in;
   logic [DIV_STEPS-1:0] quo_ff, quo_in;

   // Result register.
   logic         rsp_valid_ff, rsp_valid_in;
   logic [127:0] rsp_data_ff, rsp_data_in;

   // Combinational helpers.
   logic [31:0]        rate_u;
   logic [NUM_W-1:0]   num;
   logic [LHS_W-1:0]   lhs;
   logic [REM_W-1:0]   trial;
   logic               trial_ge;
   logic [7:0]         mag;
   logic               m_gt, m_lt;
   logic signed [17:0] mag_s;
   logic signed [17:0] bl_dn, bl_up, amount_s;
   logic [6:0]         slew_new;
   logic               dir_new;

   assign dp_stat.out_hold = rsp_valid_ff & ~rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      rate_u   = req_rate;
      num      = (slew_sel_ff ? TWO_N_SLEW : TWO_N_ONE) + NUM_W'(f_ff);
      lhs      = slew_sel_ff ? LHS_SLEW : LHS_ONE;
      trial    = {rem_ff[REM_W-2:0], numlo_ff[DIV_STEPS-1]};
      trial_ge = trial >= REM_W'(den_ff);
      mag      = step_inc_ff[7] ? 8'(-step_inc_ff) : step_inc_ff;
      mag_s    = $signed({10'b0, mag});
      m_gt     = $signed(motor_ff) > $signed(target_ff);
      m_lt     = $signed(motor_ff) < $signed(target_ff);
      bl_dn    = bl_taken_ff - mag_s;
      bl_up    = bl_taken_ff + mag_s;
      amount_s = $signed({2'b0, bl_amount_ff});
      slew_new = slew_sel_ff ? 7'(SLEW_STEP) : 7'd1;
      dir_new  = in_range_ff & dir_nz_ff;

      track_in     = track_ff;
      bl_amount_in = bl_amount_ff;
      bl_rate_in   = bl_rate_ff;
      motor_in     = motor_ff;
      target_in    = target_ff;
      bl_taken_in  = bl_taken_ff;
      bl_flag_in   = bl_flag_ff;
      step_inc_in  = step_inc_ff;
      slew_in      = slew_ff;
      period_in    = period_ff;
      f_in         = f_ff;
      dir_nz_in    = dir_nz_ff;
      dir_neg_in   = dir_neg_ff;
      f65_in       = f65_ff;
      slew_sel_in  = slew_sel_ff;
      in_range_in  = in_range_ff;
      den_in       = den_ff;
      rem_in       = rem_ff;
      numlo_in     = numlo_ff;
      quo_in       = quo_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;

      if (csr_write) begin
         case (csr_index)
            CSR_TRACK:     track_in     = csr_data[0];
            CSR_BL_AMOUNT: bl_amount_in = csr_data[15:0];
            CSR_BL_RATE:   bl_rate_in   = csr_data;
            default:       track_in     = track_ff;
         endcase
      end

      // Rate update: magnitude, then slew choice and range, then division.
      if (ctl_cmd.rate_abs) begin
         dir_nz_in  = rate_u != 32'd0;
         dir_neg_in = rate_u[31];
         f_in       = rate_u[31] ? (32'd0 - rate_u) : rate_u;
         if (bl_flag_ff) begin
            f_in = {1'b0, bl_rate_ff};
         end
      end
      if (ctl_cmd.rate_scale) begin
         f65_in      = {f_ff, 6'b0} + F65_W'(f_ff);
         slew_sel_in = !({1'b0, f_ff} <= {1'b0, bl_rate_ff, 1'b0});
      end
      if (ctl_cmd.div_init) begin
         in_range_in = F65_W'(lhs) <= f65_ff;
         den_in      = {f_ff, 1'b0};
         rem_in      = REM_W'(num >> DIV_STEPS);
         numlo_in    = num[DIV_STEPS-1:0];
      end
      if (ctl_cmd.div_step) begin
         rem_in   = trial_ge ? (trial - REM_W'(den_ff)) : trial;
         numlo_in = {numlo_ff[DIV_STEPS-2:0], 1'b0};
         quo_in   = {quo_ff[DIV_STEPS-2:0], trial_ge};
      end
      if (ctl_cmd.rate_done) begin
         slew_in   = slew_new;
         period_in = in_range_ff ? quo_ff : 31'd0;
         if (!dir_new) begin
            step_inc_in = 8'sd0;
         end else if (dir_neg_ff) begin
            step_inc_in = $signed(8'd0 - {1'b0, slew_new});
         end else begin
            step_inc_in = $signed({1'b0, slew_new});
         end
      end

      // Tick: target first, then motor or backlash toward the new target.
      if (ctl_cmd.tick_target && track_ff && !bl_flag_ff) begin
         target_in = target_ff + PW'(step_inc_ff);
      end
      if (ctl_cmd.tick_step) begin
         if (m_gt) begin
            if (bl_taken_ff > 18'sd0) begin
               bl_taken_in = bl_dn;
               bl_flag_in  = bl_dn > 18'sd0;
            end else begin
               motor_in   = motor_ff - PW'(mag);
               bl_flag_in = 1'b0;
            end
         end else if (m_lt || bl_flag_ff) begin
            if (bl_taken_ff < amount_s) begin
               bl_taken_in = bl_up;
               bl_flag_in  = bl_up < amount_s;
            end else begin
               motor_in   = motor_ff + PW'(mag);
               bl_flag_in = 1'b0;
            end
         end
      end

      if (ctl_cmd.load_pos) begin
         motor_in    = PW'(req_position);
         target_in   = PW'(req_position);
         bl_taken_in = 18'sd0;
         bl_flag_in  = 1'b0;
      end
      if (ctl_cmd.set_target) begin
         target_in = PW'(req_position);
      end

      if (ctl_cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {6'b0, step_inc_ff, period_ff, bl_flag_ff, bl_taken_ff,
                         32'(target_ff), 32'(motor_ff)};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         track_ff     <= 1'b0;
         bl_amount_ff <= '0;
         bl_rate_ff   <= '0;
         motor_ff     <= '0;
         target_ff    <= '0;
         bl_taken_ff  <= '0;
         bl_flag_ff   <= 1'b0;
         step_inc_ff  <= '0;
         slew_ff      <= 7'd1;
         period_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         track_ff     <= track_in;
         bl_amount_ff <= bl_amount_in;
         bl_rate_ff   <= bl_rate_in;
         motor_ff     <= motor_in;
         target_ff    <= target_in;
         bl_taken_ff  <= bl_taken_in;
         bl_flag_ff   <= bl_flag_in;
         step_inc_ff  <= step_inc_in;
         slew_ff      <= slew_in;
         period_ff    <= period_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      f_ff        <= f_in;
      dir_nz_ff   <= dir_nz_in;
      dir_neg_ff  <= dir_neg_in;
      f65_ff      <= f65_in;
      slew_sel_ff <= slew_sel_in;
      in_range_ff <= in_range_in;
      den_ff      <= den_in;
      rem_ff      <= rem_in;
      numlo_ff    <= numlo_in;
      quo_ff      <= quo_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ===== hw/rtl/step_tracker_with_backlash_unit.sv =====
// Step tracker with backlash take-up: input, result and configuration ports.
// A slave stream feeds commands (req_*) and a master stream returns one result
// per command (rsp_*); csr_* writes the three configuration registers.
// req_tuser selects the command: tick, set rate, load position, set target.
// Every accepted transaction yields exactly one result transaction carrying
// the motor and target positions, backlash taken, backlash flag, tick period
// and signed step per tick as they stand after the command.
// A set rate command runs one quotient bit per cycle through a 31-step
// restoring divider for the period, which sets its cost; commands are taken
// one at a time, so a new command is accepted in the cycle after the previous
// result enters the output register.
// Reset (synchronous, active high) clears positions, backlash state, the
// period, the step and the configuration, with the slew size at one.
// When the receiver holds rsp_tready low, the result waits in the output
// register and a finished command waits until that register is free.
// Configuration writes are always accepted (csr_ready is high); they are
// meant for times when no command is in flight.
module step_tracker_with_backlash_unit #(
   parameter int POSITION_WIDTH = 32,
   parameter int SLEW_STEP      = 64
) (
   input  logic          clock,
   input  logic          reset,
   // Command stream.
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [63:0]   req_tdata,   // rate [31:0], position_value [63:32]
   input  logic [1:0]    req_tuser,   // cmd [1:0]
   // Result stream.
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [127:0]  rsp_tdata,   // motor_pos [31:0], target_pos [63:32],
                                      // backlash_now [81:64], in_backlash [82],
                                      // tick_period [113:83], step_delta [121:114]
   // Configuration write channel.
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [1:0]    csr_index,
   input  logic [30:0]   csr_data
);
   import stbu_pkg::*;

   stbu_cmd_type  ctl_cmd;
   stbu_stat_type dp_stat;
   logic signed [31:0] req_rate;
   logic signed [31:0] req_position;

   assign csr_ready    = 1'b1;
   assign req_rate     = $signed(req_tdata[31:0]);
   assign req_position = $signed(req_tdata[63:32]);

   // The controller decides the step sequence for each transaction.
   stbu_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .dp_stat    (dp_stat),
      .ctl_cmd    (ctl_cmd)
   );

   // The datapath holds the positions, backlash state, configuration, the divider and the result register.
   stbu_dpath #(
      .POSITION_WIDTH (POSITION_WIDTH),
      .SLEW_STEP      (SLEW_STEP)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .ctl_cmd      (ctl_cmd),
      .dp_stat      (dp_stat),
      .req_rate     (req_rate),
      .req_position (req_position),
      .csr_write    (csr_valid & csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata)
   );

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the step tracker with backlash take-up.
// Depends on stbu_pkg (command codes, register indexes) and the top level
// step_tracker_with_backlash_unit; it needs no other files.
`timescale 1ns / 1ps

module testbench;
   import stbu_pkg::*;

   // Tracks motor, target and backlash state the way the block should, and
   // holds the result words it is expected to return, oldest first.
   class backlash_scoreboard;
      bit             track_on;
      int             bl_amount;
      longint unsigned bl_rate;
      logic [31:0]    motor;
      logic [31:0]    target;
      int             bl_taken;
      bit             bl_flag;
      int             step_inc;
      int             slew;
      logic [30:0]    period;
      logic [127:0]   expected_q[$];
      int             errors;

      function new();
         track_on  = 1'b0;
         bl_amount = 0;
         bl_rate   = 0;
         motor     = '0;
         target    = '0;
         bl_taken  = 0;
         bl_flag   = 1'b0;
         step_inc  = 0;
         slew      = 1;
         period    = '0;
         errors    = 0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [30:0] value);
         case (idx)
            CSR_TRACK:     track_on  = value[0];
            CSR_BL_AMOUNT: bl_amount = int'(value[15:0]);
            CSR_BL_RATE:   bl_rate   = 64'(value);
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // Applies one accepted command transaction and queues the result it causes.
      function void note_command(logic [1:0] cmd, logic [31:0] rate_val, logic [31:0] pos_val);
         longint unsigned mag_f;
         longint unsigned numer;
         int              dir;
         int              mag;
         case (cmd)
            CMD_TICK: begin
               mag = (step_inc < 0) ? -step_inc : step_inc;
               if (track_on && !bl_flag)
                  target = target + step_inc;
               if ($signed(motor) > $signed(target)) begin
                  if (bl_taken > 0) begin
                     bl_taken = bl_taken - mag;
                     bl_flag  = (bl_taken > 0);
                  end else begin
                     motor   = motor - mag;
                     bl_flag = 1'b0;
                  end
               end else if ($signed(motor) < $signed(target) || bl_flag) begin
                  if (bl_taken < bl_amount) begin
                     bl_taken = bl_taken + mag;
                     bl_flag  = (bl_taken < bl_amount);
                  end else begin
                     motor   = motor + mag;
                     bl_flag = 1'b0;
                  end
               end
            end
            CMD_RATE: begin
               dir = 0;
               if (rate_val == 32'd0) begin
                  mag_f = 0;
               end else if (rate_val[31]) begin
                  dir   = -1;
                  mag_f = 64'h1_0000_0000 - {32'd0, rate_val};
               end else begin
                  dir   = 1;
                  mag_f = {32'd0, rate_val};
               end
               // While backlash is being taken up the take-up rate wins, but
               // the direction still follows the commanded sign.
               if (bl_flag)
                  mag_f = bl_rate;
               slew = (mag_f <= 2 * bl_rate) ? 1 : 64;
               if (64'd2048 * slew <= 64'd65 * mag_f) begin
                  numer  = 64'd65536000000 * slew;
                  period = 31'((2 * numer + mag_f) / (2 * mag_f));
               end else begin
                  period = '0;
                  dir    = 0;
               end
               step_inc = dir * slew;
            end
            CMD_LOAD: begin
               motor    = pos_val;
               target   = pos_val;
               bl_taken = 0;
               bl_flag  = 1'b0;
            end
            default: target = pos_val;
         endcase
         expected_q.push_back({6'd0, step_inc[7:0], period, bl_flag, bl_taken[17:0],
                               target, motor});
      endfunction

      function void field_check(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            errors++;
            if (errors <= 10)
               $display("%0t: %s mismatch: expected %0h, got %0h", $realtime, name, want, got);
         end
      endfunction

      // Compares one accepted result transaction with the oldest expectation.
      function void check_result(logic [127:0] got);
         logic [127:0] want;
         if (expected_q.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("%0t: result %0h arrived with nothing expected", $realtime, got);
            return;
         end
         want = expected_q.pop_front();
         field_check("motor_pos", want[31:0], got[31:0]);
         field_check("target_pos", want[63:32], got[63:32]);
         field_check("backlash_now", 32'(want[81:64]), 32'(got[81:64]));
         field_check("in_backlash", 32'(want[82]), 32'(got[82]));
         field_check("tick_period", 32'(want[113:83]), 32'(got[113:83]));
         field_check("step_delta", 32'(want[121:114]), 32'(got[121:114]));
      endfunction
   endclass

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [63:0]   req_tdata = '0;    // rate [31:0], position_value [63:32]
   logic [1:0]    req_tuser = CMD_TICK;  // cmd [1:0]
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b1;
   logic [127:0]  rsp_tdata;         // motor_pos [31:0], target_pos [63:32],
                                     // backlash_now [81:64], in_backlash [82],
                                     // tick_period [113:83], step_delta [121:114]
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   logic [1:0]    csr_index = CSR_TRACK;
   logic [30:0]   csr_data = '0;

   backlash_scoreboard sb;
   int            issued = 0;
   bit            send_quiet = 1'b0;

   step_tracker_with_backlash_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Offers one command transaction after a random gap and returns at the edge
   // where it is accepted. Valid is only lowered when a gap is actually taken,
   // so back-to-back transactions keep it high without a glitch.
   task automatic send_cmd(input logic [1:0] cmd, input logic [31:0] rate_val,
                           input logic [31:0] pos_val);
      int gap;
      if (issued % 64 == 0)
         send_quiet = ($urandom_range(0, 3) == 0);
      gap = send_quiet ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {pos_val, rate_val};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_command(cmd, rate_val, pos_val);
      issued++;
   endtask

   // Stops offering commands and waits until every expected result is back,
   // so the block is idle before the registers change.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // One register write; the caller lowers csr_valid after the last one.
   task automatic write_reg(input logic [1:0] idx, input logic [30:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_reg(idx, value);
   endtask

   task automatic program_regs(input logic track_val, input logic [15:0] amount_val,
                               input logic [30:0] rate_val);
      write_reg(CSR_TRACK, {30'd0, track_val});
      write_reg(CSR_BL_AMOUNT, {15'd0, amount_val});
      write_reg(CSR_BL_RATE, rate_val);
      csr_valid <= 1'b0;
   endtask

   // Random commands with a bias toward ticks, so the motor and the backlash
   // counter actually chase the target. Targets mostly land near the motor,
   // and rates cluster around the range limits and the slew-size boundary.
   task automatic random_phase(input int count);
      int          sel;
      int          kind;
      logic [1:0]  cmd;
      logic [31:0] rate_val;
      logic [31:0] pos_val;
      repeat (count) begin
         sel      = $urandom_range(0, 99);
         rate_val = $urandom;
         pos_val  = $urandom;
         if (sel < 55) begin
            cmd = CMD_TICK;
         end else if (sel < 70) begin
            cmd  = CMD_RATE;
            kind = $urandom_range(0, 9);
            case (kind)
               0: rate_val = 32'd0;
               1: rate_val = $urandom_range(28, 36);
               2: rate_val = $urandom_range(2010, 2024);
               3: rate_val = 32'(sb.bl_rate * 2 + $urandom_range(0, 4) - 2);
               4: rate_val = ($urandom_range(0, 1) == 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
               5, 6: ;
               default: rate_val = $urandom_range(32, 1 << 20);
            endcase
            if (kind != 0 && kind != 4 && $urandom_range(0, 1) == 1)
               rate_val = -rate_val;
         end else if (sel < 78) begin
            cmd = CMD_LOAD;
            case ($urandom_range(0, 2))
               0: ;
               1: pos_val = $urandom_range(0, 2000) - 1000;
               default: pos_val = 32'h7FFF_FE00 + $urandom_range(0, 1023);
            endcase
         end else begin
            cmd = CMD_TARGET;
            if ($urandom_range(0, 7) != 0)
               pos_val = sb.motor + $urandom_range(0, 600) - 300;
         end
         send_cmd(cmd, rate_val, pos_val);
      end
   endtask

   // Result side: draws a ready gap per transaction, sometimes runs without
   // gaps, and once holds off for a long stretch so the block backs up into
   // its command input while the sender keeps offering.
   initial begin : result_side
      int gap;
      int taken;
      bit quiet;
      bit held;
      taken = 0;
      quiet = 1'b0;
      held  = 1'b0;
      wait (!reset);
      forever begin
         if (taken % 50 == 0)
            quiet = ($urandom_range(0, 3) == 0);
         if (!held && taken == 400) begin
            held = 1'b1;
            gap  = 500;
         end else begin
            gap = quiet ? 0 : $urandom_range(0, 9);
         end
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         sb.check_result(rsp_tdata);
         taken++;
      end
   end

   // Hard stop in case the block hangs; the slowest correct run is far shorter.
   initial begin : watchdog
      #20ms;
      $display("Test completed with failures");
      $finish;
   end

   initial begin : stimulus
      sb = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed part: backlash rate of 100 steps/s, small backlash, tracking on.
      program_regs(1'b1, 16'd4, 31'd409600);
      send_cmd(CMD_RATE, 32'd0, $urandom);            // zero rate: stopped
      send_cmd(CMD_TICK, $urandom, $urandom);         // no motion at all
      send_cmd(CMD_RATE, 32'd31, $urandom);           // just out of range
      send_cmd(CMD_RATE, 32'd32, $urandom);           // slowest period in range
      send_cmd(CMD_RATE, 32'h8000_0000, $urandom);    // most negative rate
      send_cmd(CMD_RATE, 32'h7FFF_FFFF, $urandom);    // most positive rate
      send_cmd(CMD_RATE, 32'd819200, $urandom);       // exactly twice backlash rate
      send_cmd(CMD_RATE, 32'd819201, $urandom);       // first rate with big steps
      // Near the top of the position range: tracking wraps the target negative.
      send_cmd(CMD_LOAD, $urandom, 32'h7FFF_FF80);
      send_cmd(CMD_TICK, $urandom, $urandom);
      send_cmd(CMD_TICK, $urandom, $urandom);
      send_cmd(CMD_TICK, $urandom, $urandom);
      send_cmd(CMD_RATE, 32'd4096, $urandom);
      send_cmd(CMD_TARGET, $urandom, 32'h8000_0000);  // most negative target
      send_cmd(CMD_TICK, $urandom, $urandom);
      // Reversal toward positive: backlash take-up, then a rate command while
      // take-up is still running, which forces the backlash rate.
      send_cmd(CMD_LOAD, $urandom, 32'd100);
      send_cmd(CMD_TARGET, $urandom, 32'd50);
      send_cmd(CMD_TICK, $urandom, $urandom);
      send_cmd(CMD_TARGET, $urandom, 32'd200);
      send_cmd(CMD_TICK, $urandom, $urandom);
      send_cmd(CMD_TICK, $urandom, $urandom);
      send_cmd(CMD_RATE, 32'hFFFF_E000, $urandom);
      send_cmd(CMD_TICK, $urandom, $urandom);
      send_cmd(CMD_TICK, $urandom, $urandom);
      send_cmd(CMD_TICK, $urandom, $urandom);
      drain();

      // Random phases over a spread of register settings, extremes included.
      program_regs(1'b0, 16'd0, 31'd0);
      random_phase(200);
      drain();
      program_regs(1'b1, 16'd3, 31'd204800);
      random_phase(200);
      drain();
      program_regs(1'b0, 16'd200, 31'd1000);
      random_phase(200);
      drain();
      program_regs(1'b1, 16'hFFFF, 31'h7FFF_FFFF);
      random_phase(200);
      drain();
      program_regs(1'b1, 16'($urandom_range(0, 64)), 31'($urandom));
      random_phase(200);
      drain();
      program_regs(1'b0, 16'd1, 31'd8192);
      random_phase(200);
      drain();

      // Give any stray result a chance to show up before the verdict.
      repeat (50) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
